// ----- rtl/ppp_pkg.sv -----
// Package of the perspective point plotter: state type, opcodes, register indexes,
// configuration reset values and the default frame store size.
// Used by perspective_point_plotter_unit; depends on nothing.
package ppp_pkg;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 64;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_PLOT  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_DIST   = 2'd2;
	localparam logic [1:0] CFG_OFFSET = 2'd3;

	localparam logic [7:0]  WIDTH_RST  = 8'd80;
	localparam logic [6:0]  HEIGHT_RST = 7'd44;
	localparam logic [15:0] DIST_RST   = 16'd10240;
	localparam logic [15:0] OFFSET_RST = 16'd1280;

	localparam int MUL_STEPS = 16;
	localparam int DIV_STEPS = 24;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PREP,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_FIT,
		ST_WR_RD,
		ST_WR_MOD,
		ST_RD
	} ppp_state_t;

endpackage

// ----- rtl/ppp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the frame store; depends on nothing.
module ppp_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/perspective_point_plotter_unit.sv -----
// Perspective point plotter: a one-bit frame store with clear, plot and read commands.
// A plot keeps busy high through two projections, set by the 16-step shift-add
// multiplier and the 24-step restoring divider, then a row read and write back; a zero
// depth sum ends it with status set and no write. A clear writes its MAX_ROWS rows one
// row per cycle; the result strobe follows in the cycle after a command's last state.
// Reset runs the same clearing pass with busy high; the receiver cannot stall results.
module perspective_point_plotter_unit
	import ppp_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] vertex_x,
	input  logic [15:0] vertex_y,
	input  logic [15:0] vertex_z,
	input  logic [6:0]  read_col,
	input  logic [5:0]  read_row,
	output logic        done,
	output logic        cell_marked,
	output logic [6:0]  plot_col,
	output logic [5:0]  plot_row,
	output logic        status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(MAX_COLS);
	localparam int RW = $clog2(MAX_ROWS);
	localparam logic [MAX_COLS-1:0] ROW_ONE = {{(MAX_COLS-1){1'b0}}, 1'b1};

	ppp_state_t state_q, state_d;

	logic [7:0]  screen_width_q;
	logic [6:0]  screen_height_q;
	logic [15:0] projection_distance_q;
	logic [15:0] depth_offset_q;

	logic          clr_report_q;
	logic [RW-1:0] clr_cnt_q;
	logic [4:0]    step_q;
	logic          axis_q;
	logic          done_q;

	logic [15:0] vx_q, vy_q;
	logic [16:0] den_q;
	logic [16:0] dvs_q;
	logic [7:0]  w_q;
	logic [6:0]  h_q;
	logic        sv_q;
	logic [15:0] mplier1_q;
	logic [31:0] mcand1_q;
	logic [31:0] acc1_q;
	logic [7:0]  mplier2_q;
	logic [24:0] mcand2_q;
	logic [24:0] acc2_q;
	logic [23:0] dvd_q;
	logic [16:0] rem_q;
	logic        qneg_q;
	logic [7:0]  col_q;
	logic [6:0]  row_q;
	logic [CW-1:0] rd_col_q;
	logic          rd_ok_q;
	logic          cell_marked_q;
	logic [6:0]    plot_col_q;
	logic [5:0]    plot_row_q;
	logic          status_q;

	logic [7:0]  w_eff;
	logic [6:0]  h_eff;
	logic [16:0] den_in;
	logic        den_zero;
	logic        last_row;
	logic [15:0] v_sel;
	logic [15:0] v_mag;
	logic [7:0]  s_sel;
	logic [34:0] t1, t2, t1s, t2s, sum, mag;
	logic [17:0] shifted;
	logic [18:0] diff;
	logic        ge;
	logic [23:0] q_axis;
	logic [7:0]  lim;
	logic [7:0]  fit_val;

	logic [RW+6:0]  rd_row_ext;
	logic [CW+6:0]  rd_col_ext;
	logic [RW+6:0]  row_ext;
	logic [CW+7:0]  col_ext;
	logic [RW-1:0]  row_addr;
	logic [CW-1:0]  col_idx;
	logic           rd_in_range;

	logic                ram_we;
	logic [RW-1:0]       ram_waddr;
	logic [MAX_COLS-1:0] ram_wdata;
	logic [RW-1:0]       ram_raddr;
	logic [MAX_COLS-1:0] ram_rdata;

	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign cell_marked = cell_marked_q;
	assign plot_col    = plot_col_q;
	assign plot_row    = plot_row_q;
	assign status      = status_q;

	always_comb begin
		if (screen_width_q == 8'd0) begin
			w_eff = 8'd1;
		end else if (int'(screen_width_q) > MAX_COLS) begin
			w_eff = 8'(MAX_COLS);
		end else begin
			w_eff = screen_width_q;
		end
		if (screen_height_q == 7'd0) begin
			h_eff = 7'd1;
		end else if (int'(screen_height_q) > MAX_ROWS) begin
			h_eff = 7'(MAX_ROWS);
		end else begin
			h_eff = screen_height_q;
		end
	end

	assign den_in   = {vertex_z[15], vertex_z} + {depth_offset_q[15], depth_offset_q};
	assign den_zero = (den_q == 17'd0);
	assign last_row = (clr_cnt_q == RW'(MAX_ROWS - 1));

	assign v_sel = axis_q ? vy_q : vx_q;
	assign v_mag = v_sel[15] ? (16'd0 - v_sel) : v_sel;
	assign s_sel = axis_q ? {1'b0, h_q} : w_q;

	assign t1   = {2'b00, acc1_q, 1'b0};
	assign t2   = {2'b00, acc2_q, 8'd0};
	assign t1s  = sv_q ? (35'd0 - t1) : t1;
	assign t2s  = den_q[16] ? (35'd0 - t2) : t2;
	assign sum  = t1s + t2s;
	assign mag  = sum[34] ? (35'd0 - sum) : sum;

	assign shifted = {rem_q, dvd_q[23]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
	assign ge      = !diff[18];

	assign q_axis = axis_q ? {1'b0, dvd_q[23:1]} : dvd_q;
	assign lim    = s_sel - 8'd1;
	always_comb begin
		if (qneg_q) begin
			fit_val = 8'd0;
		end else if (q_axis > {16'd0, lim}) begin
			fit_val = lim;
		end else begin
			fit_val = q_axis[7:0];
		end
	end

	assign rd_row_ext  = {{RW{1'b0}}, read_row};
	assign rd_col_ext  = {{CW{1'b0}}, read_col};
	assign row_ext     = {{RW{1'b0}}, row_q};
	assign col_ext     = {{CW{1'b0}}, col_q};
	assign row_addr    = row_ext[RW-1:0];
	assign col_idx     = col_ext[CW-1:0];
	assign rd_in_range = (int'(read_col) < MAX_COLS) && (int'(read_row) < MAX_ROWS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (opcode)
						OP_CLEAR: state_d = ST_CLEAR;
						OP_PLOT:  state_d = ST_PREP;
						OP_READ:  state_d = ST_RD;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				if (last_row) begin
					state_d = ST_IDLE;
				end
			end
			ST_PREP:   state_d = den_zero ? ST_IDLE : ST_MUL;
			ST_MUL: begin
				if (step_q == 5'(MUL_STEPS - 1)) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM:    state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == 5'(DIV_STEPS - 1)) begin
					state_d = ST_FIT;
				end
			end
			ST_FIT:    state_d = axis_q ? ST_WR_RD : ST_PREP;
			ST_WR_RD:  state_d = ST_WR_MOD;
			ST_WR_MOD: state_d = ST_IDLE;
			ST_RD:     state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = row_addr;
		ram_wdata = ram_rdata | (ROW_ONE << col_idx);
		ram_raddr = row_addr;
		unique case (state_q)
			ST_IDLE:   ram_raddr = rd_row_ext[RW-1:0];
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			ST_WR_MOD: ram_we = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q               <= ST_CLEAR;
			clr_cnt_q             <= '0;
			clr_report_q          <= 1'b0;
			step_q                <= 5'd0;
			axis_q                <= 1'b0;
			done_q                <= 1'b0;
			screen_width_q        <= WIDTH_RST;
			screen_height_q       <= HEIGHT_RST;
			projection_distance_q <= DIST_RST;
			depth_offset_q        <= OFFSET_RST;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WIDTH:  screen_width_q        <= cfg_data[7:0];
					CFG_HEIGHT: screen_height_q       <= cfg_data[6:0];
					CFG_DIST:   projection_distance_q <= cfg_data;
					CFG_OFFSET: depth_offset_q        <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					axis_q    <= 1'b0;
					clr_cnt_q <= '0;
					if (start) begin
						clr_report_q <= 1'b1;
						if (opcode != OP_CLEAR && opcode != OP_PLOT && opcode != OP_READ) begin
							done_q <= 1'b1;
						end
					end
				end
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + RW'(1);
					if (last_row) begin
						done_q <= clr_report_q;
					end
				end
				ST_PREP: begin
					step_q <= 5'd0;
					done_q <= den_zero;
				end
				ST_MUL: begin
					step_q <= (step_q == 5'(MUL_STEPS - 1)) ? 5'd0 : step_q + 5'd1;
				end
				ST_DIV:    step_q <= step_q + 5'd1;
				ST_FIT:    axis_q <= 1'b1;
				ST_WR_MOD: done_q <= 1'b1;
				ST_RD:     done_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				vx_q     <= vertex_x;
				vy_q     <= vertex_y;
				den_q    <= den_in;
				w_q      <= w_eff;
				h_q      <= h_eff;
				rd_col_q <= rd_col_ext[CW-1:0];
				rd_ok_q  <= rd_in_range;
				cell_marked_q <= 1'b0;
				plot_col_q    <= 7'd0;
				plot_row_q    <= 6'd0;
				status_q      <= 1'b0;
			end
			ST_CLEAR: begin
				cell_marked_q <= 1'b0;
				plot_col_q    <= 7'd0;
				plot_row_q    <= 6'd0;
				status_q      <= 1'b0;
			end
			ST_PREP: begin
				dvs_q     <= den_q[16] ? (17'd0 - den_q) : den_q;
				sv_q      <= v_sel[15];
				mplier1_q <= v_mag;
				mcand1_q  <= {16'd0, projection_distance_q};
				acc1_q    <= 32'd0;
				mplier2_q <= s_sel;
				mcand2_q  <= {8'd0, den_q[16] ? (17'd0 - den_q) : den_q};
				acc2_q    <= 25'd0;
				status_q  <= den_zero;
				cell_marked_q <= 1'b0;
				plot_col_q    <= 7'd0;
				plot_row_q    <= 6'd0;
			end
			ST_MUL: begin
				if (mplier1_q[0]) begin
					acc1_q <= acc1_q + mcand1_q;
				end
				if (mplier2_q[0]) begin
					acc2_q <= acc2_q + mcand2_q;
				end
				mcand1_q  <= {mcand1_q[30:0], 1'b0};
				mplier1_q <= {1'b0, mplier1_q[15:1]};
				mcand2_q  <= {mcand2_q[23:0], 1'b0};
				mplier2_q <= {1'b0, mplier2_q[7:1]};
			end
			ST_SUM: begin
				dvd_q  <= mag[32:9];
				rem_q  <= 17'd0;
				qneg_q <= sum[34] ^ den_q[16];
			end
			ST_DIV: begin
				rem_q <= ge ? diff[16:0] : shifted[16:0];
				dvd_q <= {dvd_q[22:0], ge};
			end
			ST_FIT: begin
				if (axis_q) begin
					row_q <= fit_val[6:0];
				end else begin
					col_q <= fit_val;
				end
			end
			ST_WR_MOD: begin
				cell_marked_q <= 1'b0;
				plot_col_q    <= col_q[6:0];
				plot_row_q    <= row_q[5:0];
				status_q      <= 1'b0;
			end
			ST_RD: begin
				cell_marked_q <= rd_ok_q & ram_rdata[rd_col_q];
				plot_col_q    <= 7'd0;
				plot_row_q    <= 6'd0;
				status_q      <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	ppp_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule
